// File: hw/rtl/dosort_pkg.sv
package dosort_pkg;

	localparam int MAX_ITEMS_DEF = 64;

	localparam int KIND_W  = 2;
	localparam int INDEX_W = 8;
	localparam int KEY_W   = 16;
	localparam int ENTRY_W = KIND_W + INDEX_W + KEY_W;
	localparam int DATA_W  = 24;
	localparam int USER_W  = KIND_W;

	// Sequencer program addresses.
	localparam int PC_W = 3;
	localparam logic [PC_W-1:0] P_LOAD  = 3'd0;
	localparam logic [PC_W-1:0] P_INIT  = 3'd1;
	localparam logic [PC_W-1:0] P_FETCH = 3'd2;
	localparam logic [PC_W-1:0] P_SCAN  = 3'd3;
	localparam logic [PC_W-1:0] P_WB    = 3'd4;
	localparam logic [PC_W-1:0] P_START = 3'd5;
	localparam logic [PC_W-1:0] P_EMIT  = 3'd6;

	// Jump conditions.
	localparam logic [2:0] C_ALWAYS    = 3'd0;
	localparam logic [2:0] C_LOAD_LAST = 3'd1;
	localparam logic [2:0] C_J_END     = 3'd2;
	localparam logic [2:0] C_I_END     = 3'd3;
	localparam logic [2:0] C_EMIT_LAST = 3'd4;

	// Read address sources.
	localparam logic [1:0] A_ZERO = 2'd0;
	localparam logic [1:0] A_I1   = 2'd1;
	localparam logic [1:0] A_J1   = 2'd2;
	localparam logic [1:0] A_K1   = 2'd3;

	// Write sources.
	localparam logic [1:0] W_NONE = 2'd0;
	localparam logic [1:0] W_LOAD = 2'd1;
	localparam logic [1:0] W_SWAP = 2'd2;
	localparam logic [1:0] W_I    = 2'd3;

	localparam logic [1:0] CUR_HOLD = 2'd0;
	localparam logic [1:0] CUR_LOAD = 2'd1;
	localparam logic [1:0] CUR_SWAP = 2'd2;

	localparam logic [1:0] I_HOLD = 2'd0;
	localparam logic [1:0] I_CLR  = 2'd1;
	localparam logic [1:0] I_INC  = 2'd2;

	localparam logic [1:0] J_HOLD   = 2'd0;
	localparam logic [1:0] J_SET_I1 = 2'd1;
	localparam logic [1:0] J_INC    = 2'd2;

	localparam logic [1:0] K_HOLD = 2'd0;
	localparam logic [1:0] K_CLR  = 2'd1;
	localparam logic [1:0] K_EMIT = 2'd2;

	typedef struct packed {
		logic            in_rdy;
		logic [2:0]      cond;
		logic [PC_W-1:0] pc_t;
		logic [PC_W-1:0] pc_f;
		logic [1:0]      addr_sel;
		logic [1:0]      wr_sel;
		logic [1:0]      cur_op;
		logic [1:0]      i_op;
		logic [1:0]      j_op;
		logic [1:0]      k_op;
	} ucode_t;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t uc;
		uc = '{in_rdy: 1'b0, cond: C_ALWAYS, pc_t: P_LOAD, pc_f: P_LOAD,
			addr_sel: A_ZERO, wr_sel: W_NONE, cur_op: CUR_HOLD,
			i_op: I_HOLD, j_op: J_HOLD, k_op: K_HOLD};
		unique case (pc)
			P_LOAD: begin
				uc.in_rdy = 1'b1;
				uc.cond   = C_LOAD_LAST;
				uc.pc_t   = P_INIT;
				uc.pc_f   = P_LOAD;
				uc.wr_sel = W_LOAD;
			end
			P_INIT: begin
				uc.i_op = I_CLR;
				uc.pc_t = P_FETCH;
			end
			P_FETCH: begin
				uc.cur_op   = CUR_LOAD;
				uc.j_op     = J_SET_I1;
				uc.addr_sel = A_I1;
				uc.cond     = C_J_END;
				uc.pc_t     = P_WB;
				uc.pc_f     = P_SCAN;
			end
			P_SCAN: begin
				uc.cur_op   = CUR_SWAP;
				uc.wr_sel   = W_SWAP;
				uc.j_op     = J_INC;
				uc.addr_sel = A_J1;
				uc.cond     = C_J_END;
				uc.pc_t     = P_WB;
				uc.pc_f     = P_SCAN;
			end
			P_WB: begin
				uc.wr_sel   = W_I;
				uc.i_op     = I_INC;
				uc.addr_sel = A_I1;
				uc.cond     = C_I_END;
				uc.pc_t     = P_START;
				uc.pc_f     = P_FETCH;
			end
			P_START: begin
				uc.k_op = K_CLR;
				uc.pc_t = P_EMIT;
			end
			P_EMIT: begin
				uc.k_op     = K_EMIT;
				uc.addr_sel = A_K1;
				uc.cond     = C_EMIT_LAST;
				uc.pc_t     = P_LOAD;
				uc.pc_f     = P_EMIT;
			end
			default: begin
				uc.pc_t = P_LOAD;
			end
		endcase
		return uc;
	endfunction

endpackage

// File: hw/rtl/depth_order_exchange_sorter_unit.sv
// Depth-order exchange sorter.
// Input requests arrive on the s_axis channel, one drawable item each; tlast marks
// the last item of a set. Items are stored while the block sits in its load step,
// one request per cycle. Once a set holds MAX_ITEMS items, further items are
// dropped, but a marked last item still closes the set.
// After the last item the block stops taking input and exchange-sorts the set in
// ascending key order (equal keys are swapped as well). A small microcode program
// steps one compare per cycle over the single read port of the item memory. This
// compare loop takes most of the time spent on a large set.
// The sorted items then leave on m_axis, one per cycle while the receiver takes
// them, the final one with tlast set. The result sits in an output register, so a
// stalled receiver just holds the current result and the emission pauses; the next
// set may begin loading while the final result is still waiting.
// Reset empties the set and the output register; memory contents need no reset.
module depth_order_exchange_sorter_unit
	import dosort_pkg::*;
#(
	parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // item_index [7:0], depth_key [23:8]
	input  logic [USER_W-1:0] s_axis_tuser,  // item_kind [1:0]
	input  logic              s_axis_tlast,  // end_of_set
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,  // out_index [7:0], out_key [23:8]
	output logic [USER_W-1:0] m_axis_tuser,  // out_kind [1:0]
	output logic              m_axis_tlast   // out_last
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

	logic [PC_W-1:0] pc_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   i_q;
	logic [CW-1:0]   j_q;
	logic [CW-1:0]   k_q;
	logic [ENTRY_W-1:0] cur_q;

	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [INDEX_W-1:0] out_index_q;
	logic [KEY_W-1:0]  out_key_q;
	logic              out_last_q;

	ucode_t uc;
	logic   in_acc;
	logic   out_free;
	logic   cond;
	logic   room;
	logic   swap;
	logic   emit_go;
	logic   last_k;

	logic [CW-1:0] i_p1;
	logic [CW:0]   i_p2;
	logic [CW-1:0] j_p1;
	logic [CW-1:0] k_p1;
	logic [CW-1:0] j_next;

	logic [ENTRY_W-1:0] rd_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [ENTRY_W-1:0] in_entry;

	logic signed [KEY_W-1:0] cur_key;
	logic signed [KEY_W-1:0] rd_key;

	assign uc = ucode_rom(pc_q);

	assign s_axis_tready = uc.in_rdy;
	assign in_acc   = s_axis_tvalid & s_axis_tready;
	assign out_free = ~out_valid_q | m_axis_tready;
	assign room     = cnt_q < MAX_C;

	assign i_p1 = i_q + 1'b1;
	assign i_p2 = {1'b0, i_q} + (CW+1)'(2);
	assign j_p1 = j_q + 1'b1;
	assign k_p1 = k_q + 1'b1;
	assign last_k = k_p1 == cnt_q;

	always_comb begin
		case (uc.j_op)
			J_SET_I1: j_next = i_p1;
			J_INC:    j_next = j_p1;
			default:  j_next = j_q;
		endcase
	end

	assign cur_key = signed'(cur_q[KEY_W-1:0]);
	assign rd_key  = signed'(rd_data[KEY_W-1:0]);
	// Swap on equal keys too; during the scan cur_q holds the live entry at position i.
	assign swap    = cur_key >= rd_key;

	assign emit_go = (uc.k_op == K_EMIT) && out_free;

	always_comb begin
		unique case (uc.cond)
			C_ALWAYS:    cond = 1'b1;
			C_LOAD_LAST: cond = in_acc & s_axis_tlast;
			C_J_END:     cond = j_next >= cnt_q;
			C_I_END:     cond = i_p2 >= {1'b0, cnt_q};
			C_EMIT_LAST: cond = emit_go & last_k;
			default:     cond = 1'b1;
		endcase
	end

	// Memory entry layout: kind, index, key from the top bit down.
	assign in_entry = {s_axis_tuser, s_axis_tdata[INDEX_W-1:0],
		s_axis_tdata[INDEX_W +: KEY_W]};

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = i_q[AW-1:0];
		wr_data = cur_q;
		unique case (uc.wr_sel)
			W_LOAD: begin
				wr_en   = in_acc & room;
				wr_addr = cnt_q[AW-1:0];
				wr_data = in_entry;
			end
			W_SWAP: begin
				wr_en   = swap;
				wr_addr = j_q[AW-1:0];
			end
			W_I: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		unique case (uc.addr_sel)
			A_I1:    rd_addr = i_p1[AW-1:0];
			A_J1:    rd_addr = j_p1[AW-1:0];
			A_K1:    rd_addr = k_p1[AW-1:0];
			default: rd_addr = '0;
		endcase
	end

	// While the output is stalled the read register keeps the pending entry.
	assign rd_en = (uc.k_op != K_EMIT) || out_free;

	dosort_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_ITEMS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= P_LOAD;
			cnt_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= cond ? uc.pc_t : uc.pc_f;

			if (in_acc && room) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (emit_go && last_k) begin
				cnt_q <= '0;
			end

			case (uc.i_op)
				I_CLR:   i_q <= '0;
				I_INC:   i_q <= i_p1;
				default: i_q <= i_q;
			endcase

			j_q <= j_next;

			if (uc.k_op == K_CLR) begin
				k_q <= '0;
			end else if (emit_go) begin
				k_q <= k_p1;
			end

			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (uc.cur_op)
			CUR_LOAD: cur_q <= rd_data;
			CUR_SWAP: begin
				if (swap) begin
					cur_q <= rd_data;
				end
			end
			default: cur_q <= cur_q;
		endcase

		if (emit_go) begin
			out_kind_q  <= rd_data[ENTRY_W-1 -: KIND_W];
			out_index_q <= rd_data[KEY_W +: INDEX_W];
			out_key_q   <= rd_data[KEY_W-1:0];
			out_last_q  <= last_k;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_key_q, out_index_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_C)
		else $error("item count beyond capacity");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == P_SCAN) |-> (j_q < cnt_q) && (i_q < j_q))
		else $error("compare index outside the set");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == P_EMIT) |-> (k_q < cnt_q))
		else $error("emit index outside the set");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && last_k) |=> (pc_q == P_LOAD) && (cnt_q == '0) && m_axis_tlast)
		else $error("set not closed after final result");

endmodule

// File: hw/rtl/dosort_ram.sv
module dosort_ram
	import dosort_pkg::*;
#(
	parameter int WIDTH = ENTRY_W,
	parameter int DEPTH = MAX_ITEMS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
